// File: hw/rtl/ppf_pkg.sv
`timescale 1ns / 1ps

package ppf_pkg;

	localparam int unsigned MAX_LEN_DEFAULT = 256;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	localparam logic [8:0] MIN_LENGTH_RESET      = 9'd0;
	localparam logic [8:0] MAX_LENGTH_RESET      = 9'd256;
	localparam logic [4:0] ALLOWED_CLASSES_RESET = 5'd0;
	localparam logic [2:0] MIN_CLASSES_RESET     = 3'd0;
	localparam logic [7:0] MAX_RUN_RESET         = 8'd3;

	localparam logic [7:0] RUN_CAP = 8'd255;

	// register indexes (paddr[4:2])
	localparam logic [2:0] REG_MIN_LENGTH      = 3'd0;
	localparam logic [2:0] REG_MAX_LENGTH      = 3'd1;
	localparam logic [2:0] REG_ALLOWED_CLASSES = 3'd2;
	localparam logic [2:0] REG_MIN_CLASSES     = 3'd3;
	localparam logic [2:0] REG_MAX_RUN         = 3'd4;

	// fail reasons
	localparam logic [2:0] REASON_OK      = 3'd0;
	localparam logic [2:0] REASON_LENGTH  = 3'd1;
	localparam logic [2:0] REASON_CLASS   = 3'd2;
	localparam logic [2:0] REASON_VARIETY = 3'd3;
	localparam logic [2:0] REASON_RUN     = 3'd4;

	// class bits
	localparam logic [4:0] CLASS_LOWER = 5'b00001;
	localparam logic [4:0] CLASS_UPPER = 5'b00010;
	localparam logic [4:0] CLASS_DIGIT = 5'b00100;
	localparam logic [4:0] CLASS_PUNCT = 5'b01000;
	localparam logic [4:0] CLASS_OTHER = 5'b10000;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       has_byte;
		logic       last;
	} ppf_item_t;

	typedef struct packed {
		logic       accept;
		logic [2:0] fail_reason;
		logic [8:0] pw_length;
		logic [4:0] classes_seen;
	} ppf_result_t;

	typedef struct packed {
		logic [8:0] min_length;
		logic [8:0] max_length;
		logic [4:0] allowed_classes;
		logic [2:0] min_classes;
		logic [7:0] max_run;
	} ppf_cfg_t;

	function automatic logic [4:0] class_bit(input logic [7:0] b);
		logic [4:0] c;
		if (b >= 8'h61 && b <= 8'h7A) begin
			c = CLASS_LOWER;
		end else if (b >= 8'h41 && b <= 8'h5A) begin
			c = CLASS_UPPER;
		end else if (b >= 8'h30 && b <= 8'h39) begin
			c = CLASS_DIGIT;
		end else if (b >= 8'h20 && b <= 8'h7E) begin
			c = CLASS_PUNCT;
		end else begin
			c = CLASS_OTHER;
		end
		return c;
	endfunction

	function automatic logic [2:0] popcount5(input logic [4:0] m);
		logic [2:0] n;
		n = 3'd0;
		for (int i = 0; i < 5; i++) begin
			n = n + {2'b00, m[i]};
		end
		return n;
	endfunction

endpackage

// File: hw/rtl/ppf_regs.sv
`timescale 1ns / 1ps

module ppf_regs
	import ppf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output ppf_cfg_t          cfg
);

	ppf_cfg_t   cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_length      <= MIN_LENGTH_RESET;
			cfg_q.max_length      <= MAX_LENGTH_RESET;
			cfg_q.allowed_classes <= ALLOWED_CLASSES_RESET;
			cfg_q.min_classes     <= MIN_CLASSES_RESET;
			cfg_q.max_run         <= MAX_RUN_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_MIN_LENGTH:      cfg_q.min_length      <= pwdata[8:0];
				REG_MAX_LENGTH:      cfg_q.max_length      <= pwdata[8:0];
				REG_ALLOWED_CLASSES: cfg_q.allowed_classes <= pwdata[4:0];
				REG_MIN_CLASSES:     cfg_q.min_classes     <= pwdata[2:0];
				REG_MAX_RUN:         cfg_q.max_run         <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MIN_LENGTH:      prdata = {23'd0, cfg_q.min_length};
			REG_MAX_LENGTH:      prdata = {23'd0, cfg_q.max_length};
			REG_ALLOWED_CLASSES: prdata = {27'd0, cfg_q.allowed_classes};
			REG_MIN_CLASSES:     prdata = {29'd0, cfg_q.min_classes};
			REG_MAX_RUN:         prdata = {24'd0, cfg_q.max_run};
			default:             prdata = '0;
		endcase
	end

endmodule

// File: hw/rtl/ppf_track.sv
`timescale 1ns / 1ps

module ppf_track
	import ppf_pkg::*;
#(
	parameter int unsigned MAX_LEN = MAX_LEN_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  ppf_item_t   item,
	input  ppf_cfg_t    cfg,
	output ppf_result_t result
);

	localparam int unsigned LEN_W = $clog2(MAX_LEN + 2);
	localparam int unsigned CMP_W = (LEN_W > 9) ? LEN_W : 9;
	localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'(MAX_LEN + 1);

	logic [LEN_W-1:0] len_q, len_d;
	logic [4:0]       seen_q, seen_d;
	logic             bad_q, bad_d;
	logic [7:0]       prev_q, prev_d;
	logic [7:0]       run_q, run_d;
	logic             exceeded_q, exceeded_d;

	logic [4:0]       cls;
	logic             cont;
	logic [8:0]       next_run;
	logic [CMP_W-1:0] len_x;
	logic             len_ok;
	logic [2:0]       need;
	logic [2:0]       have;
	logic [2:0]       reason;

	assign cls      = class_bit(item.char_byte);
	assign cont     = ({1'b0, item.char_byte} == {1'b0, prev_q}) ||
	                  ({1'b0, item.char_byte} == ({1'b0, prev_q} + 9'd1));
	assign next_run = {1'b0, run_q} + 9'd1;

	always_comb begin
		len_d      = len_q;
		seen_d     = seen_q;
		bad_d      = bad_q;
		prev_d     = prev_q;
		run_d      = run_q;
		exceeded_d = exceeded_q;
		if (item.has_byte) begin
			seen_d = seen_q | cls;
			if ((cfg.allowed_classes & cls) == 5'd0) begin
				bad_d = 1'b1;
			end
			if (len_q == '0) begin
				run_d = 8'd1;
			end else if (cont) begin
				if (next_run > {1'b0, cfg.max_run}) begin
					exceeded_d = 1'b1;
				end
				run_d = (run_q == RUN_CAP) ? RUN_CAP : next_run[7:0];
			end else begin
				run_d = 8'd1;
			end
			prev_d = item.char_byte;
			if (len_q != LEN_SAT) begin
				len_d = len_q + LEN_W'(1);
			end
		end
	end

	assign len_x  = CMP_W'(len_d);
	assign len_ok = (len_d != LEN_SAT) &&
	                (len_x >= CMP_W'(cfg.min_length)) &&
	                (len_x <= CMP_W'(cfg.max_length));
	assign need   = (cfg.min_classes == 3'd0) ? popcount5(cfg.allowed_classes)
	                                          : cfg.min_classes;
	assign have   = popcount5(seen_d & cfg.allowed_classes);

	always_comb begin
		priority if (!len_ok) begin
			reason = REASON_LENGTH;
		end else if (bad_d) begin
			reason = REASON_CLASS;
		end else if (have < need) begin
			reason = REASON_VARIETY;
		end else if (exceeded_d || cfg.max_run == 8'd0) begin
			reason = REASON_RUN;
		end else begin
			reason = REASON_OK;
		end
	end

	assign result.accept       = (reason == REASON_OK);
	assign result.fail_reason  = reason;
	assign result.pw_length    = len_x[8:0];
	assign result.classes_seen = seen_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			seen_q     <= '0;
			bad_q      <= 1'b0;
			prev_q     <= '0;
			run_q      <= '0;
			exceeded_q <= 1'b0;
		end else if (step) begin
			if (item.last) begin
				len_q      <= '0;
				seen_q     <= '0;
				bad_q      <= 1'b0;
				prev_q     <= '0;
				run_q      <= '0;
				exceeded_q <= 1'b0;
			end else begin
				len_q      <= len_d;
				seen_q     <= seen_d;
				bad_q      <= bad_d;
				prev_q     <= prev_d;
				run_q      <= run_d;
				exceeded_q <= exceeded_d;
			end
		end
	end

endmodule

// File: hw/rtl/password_policy_filter.sv
`timescale 1ns / 1ps
// An accepted item is held in the input register; a closing item's result is then
// registered for the result port. Throughput: one item per cycle while no item
// waits, set by the state update in ppf_track. A closing item waits in the input
// register only while the previous result is still held on the result port.
// Reset: arst_n clears the registers to their defaults and all per-password state.

module password_policy_filter
	import ppf_pkg::*;
#(
	parameter int unsigned MAX_LEN = MAX_LEN_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              item_valid,
	output logic              item_ready,
	input  ppf_item_t         item,
	output logic              result_valid,
	input  logic              result_ready,
	output ppf_result_t       result
);

	ppf_cfg_t    cfg;
	logic        valid_s1;
	ppf_item_t   item_s1;
	logic        advance;
	logic        fire;
	ppf_result_t judged;
	logic        valid_s2;
	ppf_result_t result_s2;

	ppf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ppf_track #(
		.MAX_LEN (MAX_LEN)
	) u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (judged)
	);

	assign advance    = valid_s1 && (!item_s1.last || !valid_s2 || result_ready);
	assign fire       = advance && item_s1.last;
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= judged;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

// File: hw/rtl/ppf_checker.sv
`timescale 1ns / 1ps

module ppf_checker
	import ppf_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_ready,
	input ppf_result_t result
);

	// a held result stays put until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_accept_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.accept == (result.fail_reason == REASON_OK)))
		else $error("accept disagrees with fail_reason");

	a_reason_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.fail_reason == REASON_OK ||
		                  result.fail_reason == REASON_LENGTH ||
		                  result.fail_reason == REASON_CLASS ||
		                  result.fail_reason == REASON_VARIETY ||
		                  result.fail_reason == REASON_RUN))
		else $error("fail_reason out of range");

	// no class seen means no byte counted
	a_empty_length: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.classes_seen == 5'd0 |-> result.pw_length == 9'd0)
		else $error("length without any byte class");

endmodule

bind password_policy_filter ppf_checker u_ppf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

// File: dv/password_policy_filter_test.sv
`timescale 1ns / 1ps

module password_policy_filter_test;
	import ppf_pkg::*;

	localparam int PW_MAX = MAX_LEN_DEFAULT;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE_CYCLES = 6;

	typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_mode_e;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              item_valid = 1'b0;
	logic              item_ready;
	ppf_item_t         item = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	ppf_result_t       result;

	password_policy_filter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// policy as last written, and the per-password tracking state
	ppf_cfg_t policy = '{
		min_length: MIN_LENGTH_RESET,
		max_length: MAX_LENGTH_RESET,
		allowed_classes: ALLOWED_CLASSES_RESET,
		min_classes: MIN_CLASSES_RESET,
		max_run: MAX_RUN_RESET
	};
	logic [8:0] pw_len = '0;
	logic [4:0] pw_seen = '0;
	logic       pw_stray = 1'b0;
	logic [7:0] pw_prev = '0;
	logic [7:0] pw_run = '0;
	logic       pw_run_over = 1'b0;

	ppf_item_t   pending_q[$];
	ppf_result_t verdict_q[$];
	ppf_result_t verdict_head;
	logic [7:0]  word_q[$];

	int items_queued = 0;
	int passwords_queued = 0;
	int items_taken = 0;
	int results_seen = 0;
	int mismatches = 0;
	int reason_hits[5] = '{default: 0};
	int burst_left = 0;
	int gap_left = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	int mode_left = 0;
	rx_mode_e rx_mode = RX_ALWAYS;
	int idle_cycles = 0;

	function automatic logic [4:0] class_of(input logic [7:0] b);
		if (b inside {[8'h61:8'h7A]}) return CLASS_LOWER;
		if (b inside {[8'h41:8'h5A]}) return CLASS_UPPER;
		if (b inside {[8'h30:8'h39]}) return CLASS_DIGIT;
		if (b inside {[8'h20:8'h7E]}) return CLASS_PUNCT;
		return CLASS_OTHER;
	endfunction

	task automatic track_password(input ppf_item_t it);
		logic [4:0]  cls;
		int          next_run;
		int          need;
		ppf_result_t v;
		if (it.has_byte) begin
			cls = class_of(it.char_byte);
			pw_seen |= cls;
			if ((policy.allowed_classes & cls) == '0) pw_stray = 1'b1;
			if (pw_len == 0) begin
				pw_run = 8'd1;
			end else if (int'(it.char_byte) == int'(pw_prev) ||
					int'(it.char_byte) == int'(pw_prev) + 1) begin
				next_run = int'(pw_run) + 1;
				if (next_run > int'(policy.max_run)) pw_run_over = 1'b1;
				pw_run = (next_run > 255) ? 8'd255 : 8'(next_run);
			end else begin
				pw_run = 8'd1;
			end
			pw_prev = it.char_byte;
			if (int'(pw_len) <= PW_MAX) pw_len = pw_len + 9'd1;
		end
		if (it.last) begin
			need = (policy.min_classes == 0) ? $countones(policy.allowed_classes) :
				int'(policy.min_classes);
			if (int'(pw_len) > PW_MAX || pw_len < policy.min_length ||
					pw_len > policy.max_length) begin
				v.fail_reason = REASON_LENGTH;
			end else if (pw_stray) begin
				v.fail_reason = REASON_CLASS;
			end else if ($countones(pw_seen & policy.allowed_classes) < need) begin
				v.fail_reason = REASON_VARIETY;
			end else if (pw_run_over || policy.max_run == 0) begin
				v.fail_reason = REASON_RUN;
			end else begin
				v.fail_reason = REASON_OK;
			end
			v.accept = (v.fail_reason == REASON_OK);
			v.pw_length = pw_len;
			v.classes_seen = pw_seen;
			verdict_q.push_back(v);
			pw_len = '0;
			pw_seen = '0;
			pw_stray = 1'b0;
			pw_prev = '0;
			pw_run = '0;
			pw_run_over = 1'b0;
		end
	endtask

	// sender: bursts of random length separated by random gaps
	always @(posedge clk) begin
		if (item_valid && item_ready) begin
			track_password(item);
			items_taken++;
		end
		if (!item_valid || item_ready) begin
			if (gap_left > 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (pending_q.size() > 0) begin
				item <= pending_q.pop_front();
				item_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern of its own, plus long hold-offs on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else if (holds_served != hold_requests) begin
			holds_served++;
			hold_left = LONG_HOLD;
			result_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_e'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 120);
			end else begin
				mode_left--;
			end
			case (rx_mode)
				RX_ALWAYS: result_ready <= 1'b1;
				RX_COIN:   result_ready <= 1'($urandom_range(0, 1));
				RX_MOSTLY: result_ready <= ($urandom_range(0, 4) != 0);
				default:   result_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (result_valid && result_ready) begin
			results_seen++;
			if (result.fail_reason <= REASON_RUN) reason_hits[result.fail_reason]++;
			if (verdict_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result: accept %0b reason %0d length %0d classes %05b",
						result.accept, result.fail_reason, result.pw_length,
						result.classes_seen);
				end
			end else begin
				verdict_head = verdict_q.pop_front();
				if (result.accept !== verdict_head.accept ||
						result.fail_reason !== verdict_head.fail_reason ||
						result.pw_length !== verdict_head.pw_length ||
						result.classes_seen !== verdict_head.classes_seen) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at %0t: expected accept %0b reason %0d %s",
							$realtime, verdict_head.accept, verdict_head.fail_reason,
							"(length, classes below)");
						$display("  expected length %0d classes %05b",
							verdict_head.pw_length, verdict_head.classes_seen);
						$display("  got accept %0b reason %0d length %0d classes %05b",
							result.accept, result.fail_reason, result.pw_length,
							result.classes_seen);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
				idle_cycles, verdict_q.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apply_policy(input ppf_cfg_t c);
		write_reg(REG_MIN_LENGTH, DATA_W'(c.min_length));
		write_reg(REG_MAX_LENGTH, DATA_W'(c.max_length));
		write_reg(REG_ALLOWED_CLASSES, DATA_W'(c.allowed_classes));
		write_reg(REG_MIN_CLASSES, DATA_W'(c.min_classes));
		write_reg(REG_MAX_RUN, DATA_W'(c.max_run));
		policy = c;
	endtask

	// wait until everything queued has gone in and every verdict has come out
	task automatic settle();
		do @(posedge clk);
		while (pending_q.size() != 0 || item_valid || verdict_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_item(input logic [7:0] b, input logic has, input logic fin);
		ppf_item_t it;
		it.char_byte = b;
		it.has_byte = has;
		it.last = fin;
		pending_q.push_back(it);
		if (has || fin) items_queued++;
	endtask

	task automatic push_text(input string s, input bit by_marker);
		for (int i = 0; i < s.len(); i++) begin
			push_item(s[i], 1'b1, !by_marker && i == s.len() - 1);
		end
		if (by_marker) push_item(8'h00, 1'b0, 1'b1);
	endtask

	function automatic logic [4:0] pick_class(input logic [4:0] mask);
		logic [4:0] c;
		do c = 5'b00001 << $urandom_range(0, 4);
		while (mask != '0 && (c & mask) == '0);
		return c;
	endfunction

	function automatic logic [7:0] byte_of_class(input logic [4:0] cls);
		int r;
		case (cls)
			CLASS_LOWER: return 8'($urandom_range(8'h61, 8'h7A));
			CLASS_UPPER: return 8'($urandom_range(8'h41, 8'h5A));
			CLASS_DIGIT: return 8'($urandom_range(8'h30, 8'h39));
			CLASS_PUNCT: begin
				r = $urandom_range(0, 32);
				if (r < 16) return 8'(8'h20 + r);
				if (r < 23) return 8'(8'h3A + r - 16);
				if (r < 29) return 8'(8'h5B + r - 23);
				return 8'(8'h7B + r - 29);
			end
			default: begin
				r = $urandom_range(0, 160);
				if (r < 32) return 8'(r);
				if (r == 32) return 8'h7F;
				return 8'(8'h80 + r - 33);
			end
		endcase
	endfunction

	function automatic int pick_length();
		int r;
		int bound;
		r = $urandom_range(0, 9);
		if (r < 6) return $urandom_range(0, 12);
		if (r < 9) begin
			bound = ($urandom_range(0, 1) == 0) ? int'(policy.min_length) :
				int'(policy.max_length);
			bound = bound - 1 + int'($urandom_range(0, 2));
			if (bound >= 0 && bound <= 40) return bound;
		end
		return $urandom_range(13, 40);
	endfunction

	function automatic ppf_cfg_t random_policy();
		ppf_cfg_t c;
		int r;
		r = $urandom_range(0, 9);
		c.min_length = (r < 2) ? 9'd0 : (r == 2) ? 9'd256 : 9'($urandom_range(0, 8));
		r = $urandom_range(0, 9);
		c.max_length = (r == 0) ? 9'd0 :
			(r < 3 || c.min_length > 9'd239) ? 9'd256 :
			9'(c.min_length + $urandom_range(0, 16));
		r = $urandom_range(0, 9);
		c.allowed_classes = (r < 3) ? 5'h1F : (r == 3) ? 5'h00 : 5'($urandom_range(1, 31));
		r = $urandom_range(0, 9);
		c.min_classes = (r < 5) ? 3'($urandom_range(0, 2)) : 3'($urandom_range(0, 7));
		r = $urandom_range(0, 9);
		c.max_run = (r == 0) ? 8'd0 : (r == 1) ? 8'd1 : (r == 2) ? 8'd255 :
			8'($urandom_range(2, 6));
		return c;
	endfunction

	// candidate words: mostly in the enabled classes, some with runs, strays or raw bytes
	task automatic make_word(input int n);
		int style;
		int stray_at;
		int run_odds;
		logic [7:0] b;
		word_q.delete();
		style = $urandom_range(0, 9);
		stray_at = $urandom_range(0, (n > 0) ? n - 1 : 0);
		run_odds = (style == 5 || style == 6) ? 75 : (style <= 4) ? 20 : 0;
		for (int i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(0, 99) < run_odds) begin
				b = word_q[i - 1] + 8'($urandom_range(0, 1));
			end else if (style == 7) begin
				b = 8'($urandom_range(0, 255));
			end else if (style >= 8 && i == stray_at) begin
				b = byte_of_class(pick_class(5'h1F));
			end else begin
				b = byte_of_class(pick_class(policy.allowed_classes));
			end
			word_q.push_back(b);
		end
	endtask

	task automatic send_word();
		bit by_marker;
		int n;
		n = word_q.size();
		by_marker = (n == 0) || ($urandom_range(0, 5) == 0);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 11) == 0) push_item(8'($urandom), 1'b0, 1'b0);
			push_item(word_q[i], 1'b1, !by_marker && i == n - 1);
		end
		if (by_marker) push_item(8'($urandom), 1'b0, 1'b1);
		passwords_queued++;
	endtask

	initial begin
		ppf_cfg_t c;
		int phase;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset policy: empty line passes, any byte is outside the (empty) class set
		push_item(8'h00, 1'b0, 1'b1);
		push_text("a", 1'b0);
		settle();
		apply_policy('{min_length: 9'd4, max_length: 9'd8, allowed_classes: 5'h1F,
			min_classes: 3'd0, max_run: 8'd3});
		push_item(8'h00, 1'b1, 1'b0);
		push_text("Ab1.", 1'b0);
		push_text("ab", 1'b0);
		push_item(8'h01, 1'b1, 1'b0);
		push_text("aaaaZ1!", 1'b0);
		push_item(8'h5A, 1'b0, 1'b0);
		push_item(8'hFF, 1'b1, 1'b0);
		push_text("Zz9 ", 1'b1);
		settle();
		apply_policy('{min_length: 9'd0, max_length: 9'd256, allowed_classes: CLASS_LOWER,
			min_classes: 3'd7, max_run: 8'd0});
		push_text("xy", 1'b0);
		settle();
		apply_policy('{min_length: 9'd0, max_length: 9'd256, allowed_classes: CLASS_LOWER,
			min_classes: 3'd1, max_run: 8'd0});
		push_text("q", 1'b0);
		// policy change with a password half way through
		push_item("k", 1'b1, 1'b0);
		settle();
		write_reg(REG_MAX_RUN, DATA_W'(8'd255));
		policy.max_run = 8'd255;
		push_text("l", 1'b0);

		items_queued = 0;
		passwords_queued = 0;
		phase = 0;
		while (items_queued < 560) begin
			settle();
			if (phase == 2) begin
				c = '{min_length: 9'd0, max_length: 9'd256, allowed_classes: 5'h1F,
					min_classes: 3'd1, max_run: 8'd255};
			end else begin
				c = random_policy();
			end
			apply_policy(c);
			if (phase == 1) hold_requests++;
			if (phase == 2) begin
				word_q.delete();
				repeat (PW_MAX + 2) word_q.push_back(8'h61);
				send_word();
			end
			repeat ($urandom_range(8, 15)) begin
				make_word(pick_length());
				send_word();
			end
			phase++;
		end
		settle();
		repeat (4) @(posedge clk);

		$display("covered %0d transactions in, %0d results out, %0d passwords, %0d policies",
			items_taken, results_seen, passwords_queued, phase);
		$display("verdicts seen: ok %0d, length %0d, class %0d, variety %0d, run %0d",
			reason_hits[REASON_OK], reason_hits[REASON_LENGTH], reason_hits[REASON_CLASS],
			reason_hits[REASON_VARIETY], reason_hits[REASON_RUN]);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
